@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file mkdlp_checker.sv
// no dependencies; every macro samples on clk and is disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clk, off while rst is high
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst is high
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mkdlp_pkg.sv @@
// shared types and constants for the multi-key debounce / long-press core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mkdlp_pkg;

  // default number of keys
  localparam int KEY_COUNT_DEF = 4;

  // field widths
  localparam int TIME_W    = 32;
  localparam int MS_W      = 16;
  localparam int PIN_BITS  = 4;
  localparam int KEY_IDX_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd2;

  // register reset values
  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [MS_W-1:0] LONG_RST     = 16'd1000;

  // item operations
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_GET  = 1'b1
  } op_t;

  // per-key phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  // latched key event
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // timing limits handed to every lane
  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
  } timing_t;

  // per-lane command for one accepted word
  typedef struct packed {
    logic scan;   // scan word accepted
    logic clear;  // get word for this key accepted
    logic down;   // sampled level equals the active level
  } lane_cmd_t;

endpackage

`default_nettype wire

@@ rtl/mkdlp_lane.sv @@
// one key lane: phase machine, phase start time and latched event
// depends on mkdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mkdlp_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mkdlp_pkg::timing_t            timing,
  input  wire mkdlp_pkg::lane_cmd_t          cmd,
  input  wire logic [mkdlp_pkg::TIME_W-1:0]  now_ms,
  output mkdlp_pkg::event_t                  pending
);

  mkdlp_pkg::phase_t               phase;
  mkdlp_pkg::phase_t               phase_next;
  logic [mkdlp_pkg::TIME_W-1:0]    phase_start;
  logic [mkdlp_pkg::TIME_W-1:0]    elapsed;
  logic                            deb_over;
  logic                            long_over;
  logic                            start_load;
  logic                            latch_click;
  logic                            latch_long;

  // wrapping elapsed time and strict limit compares
  assign elapsed   = now_ms - phase_start;
  assign deb_over  = elapsed > {{(mkdlp_pkg::TIME_W - mkdlp_pkg::MS_W){1'b0}},
                                timing.debounce_ms};
  assign long_over = elapsed > {{(mkdlp_pkg::TIME_W - mkdlp_pkg::MS_W){1'b0}},
                                timing.long_press_ms};

  // next phase
  always_comb begin
    phase_next = phase;
    if (cmd.scan) begin
      unique case (phase)
        mkdlp_pkg::PH_IDLE: begin
          if (cmd.down) phase_next = mkdlp_pkg::PH_DEBOUNCE;
        end
        mkdlp_pkg::PH_DEBOUNCE: begin
          if (deb_over) begin
            phase_next = cmd.down ? mkdlp_pkg::PH_PRESSED : mkdlp_pkg::PH_IDLE;
          end
        end
        mkdlp_pkg::PH_PRESSED: begin
          if (!cmd.down) phase_next = mkdlp_pkg::PH_IDLE;
          else if (long_over) phase_next = mkdlp_pkg::PH_LONG;
        end
        mkdlp_pkg::PH_LONG: begin
          if (!cmd.down) phase_next = mkdlp_pkg::PH_IDLE;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // start-time load and event latch strobes
  always_comb begin
    start_load  = 1'b0;
    latch_click = 1'b0;
    latch_long  = 1'b0;
    if (cmd.scan) begin
      unique case (phase)
        mkdlp_pkg::PH_IDLE:     start_load  = cmd.down;
        mkdlp_pkg::PH_DEBOUNCE: start_load  = deb_over && cmd.down;
        mkdlp_pkg::PH_PRESSED: begin
          latch_click = !cmd.down;
          latch_long  = cmd.down && long_over;
        end
        default: start_load = 1'b0;
      endcase
    end
  end

  // lane state; a newer event replaces an unread one
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mkdlp_pkg::PH_IDLE;
      phase_start <= '0;
      pending     <= mkdlp_pkg::EV_NONE;
    end else begin
      phase <= phase_next;
      if (start_load) phase_start <= now_ms;
      priority if (latch_click) pending <= mkdlp_pkg::EV_CLICK;
      else if (latch_long)      pending <= mkdlp_pkg::EV_LONG;
      else if (cmd.clear)       pending <= mkdlp_pkg::EV_NONE;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mkdlp_merge.sv @@
// merge stage: picks the addressed lane's event and queues it in a
// two-word output buffer; depends on mkdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mkdlp_merge #(
  parameter int KEY_COUNT = mkdlp_pkg::KEY_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire logic [mkdlp_pkg::KEY_IDX_W-1:0]   key_index,
  input  wire mkdlp_pkg::event_t                 lane_ev [KEY_COUNT],
  output logic                                   space,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mkdlp_pkg::event_t                      out_ev
);

  localparam int SEL_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic [1:0]          cnt;
  logic [1:0]          cnt_next;
  mkdlp_pkg::event_t   ev0;
  mkdlp_pkg::event_t   ev0_next;
  mkdlp_pkg::event_t   ev1;
  mkdlp_pkg::event_t   ev1_next;
  mkdlp_pkg::event_t   push_ev;
  logic                in_range;
  logic                pop;

  // select the addressed lane, none when out of range
  assign in_range = {{(32 - mkdlp_pkg::KEY_IDX_W){1'b0}}, key_index} < 32'(KEY_COUNT);
  assign push_ev  = in_range ? lane_ev[key_index[SEL_W-1:0]] : mkdlp_pkg::EV_NONE;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign space     = (cnt != 2'd2);
  assign out_ev    = ev0;

  // buffer next values
  always_comb begin
    cnt_next = cnt;
    ev0_next = ev0;
    ev1_next = ev1;
    unique case ({push, pop})
      2'b10: begin
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd0) ev0_next = push_ev;
        else             ev1_next = push_ev;
      end
      2'b01: begin
        cnt_next = cnt - 2'd1;
        ev0_next = ev1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          ev0_next = push_ev;
        end else begin
          ev0_next = ev1;
          ev1_next = push_ev;
        end
      end
      default: cnt_next = cnt;
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) cnt <= 2'd0;
    else     cnt <= cnt_next;
  end

  // buffered words
  always_ff @(posedge clk) begin
    ev0 <= ev0_next;
    ev1 <= ev1_next;
  end

endmodule

`default_nettype wire

@@ rtl/multi_key_debounce_long_press_core.sv @@
// top level: configuration registers, KEY_COUNT key lanes and the merge stage
// depends on mkdlp_pkg, mkdlp_lane and mkdlp_merge
// a get word's key_event is registered in the output buffer and shown behind any older results
// throughput: one word per cycle while in_ready is high, scan or get; every lane updates in the scan's cycle
// in_ready drops only while two results wait in the two-word output buffer
// reset: keys idle with no event, registers at 20 ms, 1000 ms, active level 0
`timescale 1ns / 1ps
`default_nettype none

module multi_key_debounce_long_press_core #(
  parameter int KEY_COUNT = mkdlp_pkg::KEY_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               operation,
  input  wire logic [mkdlp_pkg::TIME_W-1:0]       now_ms,
  input  wire logic [mkdlp_pkg::PIN_BITS-1:0]     pin_levels,
  input  wire logic [mkdlp_pkg::KEY_IDX_W-1:0]    key_index,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              key_event,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mkdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mkdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mkdlp_pkg::timing_t   timing;
  logic                 active_level;
  logic                 in_fire;
  logic                 scan_fire;
  logic                 get_fire;
  mkdlp_pkg::event_t    lane_ev [KEY_COUNT];
  mkdlp_pkg::event_t    out_ev;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign scan_fire = in_fire && (mkdlp_pkg::op_t'(operation) == mkdlp_pkg::OP_SCAN);
  assign get_fire  = in_fire && (mkdlp_pkg::op_t'(operation) == mkdlp_pkg::OP_GET);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.debounce_ms   <= mkdlp_pkg::DEBOUNCE_RST;
      timing.long_press_ms <= mkdlp_pkg::LONG_RST;
      active_level         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mkdlp_pkg::CFG_DEBOUNCE: timing.debounce_ms   <= cfg_data;
        mkdlp_pkg::CFG_LONG:     timing.long_press_ms <= cfg_data;
        mkdlp_pkg::CFG_ACTIVE:   active_level         <= cfg_data[0];
        default:                 active_level         <= active_level;
      endcase
    end
  end

  // key lanes; keys past the pin word read level 0
  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
    logic                 level;
    mkdlp_pkg::lane_cmd_t cmd;

    if (i < mkdlp_pkg::PIN_BITS) begin : g_pin
      assign level = pin_levels[i];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    assign cmd.scan  = scan_fire;
    assign cmd.clear = get_fire && (key_index == mkdlp_pkg::KEY_IDX_W'(i));
    assign cmd.down  = (level == active_level);

    mkdlp_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .timing  (timing),
      .cmd     (cmd),
      .now_ms  (now_ms),
      .pending (lane_ev[i])
    );
  end

  // merge the addressed lane into the output buffer
  mkdlp_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (get_fire),
    .key_index (key_index),
    .lane_ev   (lane_ev),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ev    (out_ev)
  );

  assign key_event = out_ev;

endmodule

`default_nettype wire

@@ rtl/mkdlp_checker.sv @@
// port-level checks for the debounce core, bound to the top level
// depends on mkdlp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mkdlp_checker #(
  parameter int KEY_COUNT = mkdlp_pkg::KEY_COUNT_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              operation,
  input wire logic [mkdlp_pkg::KEY_IDX_W-1:0]   key_index,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [1:0]                        key_event
);

  logic in_fire;
  logic get_fire;
  logic scan_fire;
  logic idx_out;

  assign in_fire   = in_valid && in_ready;
  assign get_fire  = in_fire && (operation == mkdlp_pkg::OP_GET);
  assign scan_fire = in_fire && (operation == mkdlp_pkg::OP_SCAN);
  assign idx_out   = {{(32 - mkdlp_pkg::KEY_IDX_W){1'b0}}, key_index} >= 32'(KEY_COUNT);

  // a stalled result word stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(key_event), "result changed while stalled")

  // a scan never produces a result word
  `ASSERT_NEXT(a_scan_silent, scan_fire && !out_valid, !out_valid, "scan produced a result")

  // a get for a missing key, taken while the output buffer is empty, returns none on the next cycle
  `ASSERT_NEXT(a_get_range, get_fire && idx_out && !out_valid,
               out_valid && (key_event == mkdlp_pkg::EV_NONE), "bad key did not read none")

  // only defined event codes reach the port
  `ASSERT_IMPL(a_ev_code, out_valid, key_event != 2'd3, "undefined event code")

endmodule

bind multi_key_debounce_long_press_core mkdlp_checker #(
  .KEY_COUNT (KEY_COUNT)
) u_mkdlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .operation (operation),
  .key_index (key_index),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_event (key_event)
);

`default_nettype wire

@@ tb/sv/tb_multi_key_debounce_long_press_core.sv @@
// self-checking testbench for multi_key_debounce_long_press_core
// depends on mkdlp_pkg and the core; a scoreboard class tracks every key and queues get results
`timescale 1ns / 1ps

module tb_multi_key_debounce_long_press_core;

  localparam int NKEYS = mkdlp_pkg::KEY_COUNT_DEF;
  // configuration index with no register behind it
  localparam logic [mkdlp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic                             operation;
  logic [mkdlp_pkg::TIME_W-1:0]     now_ms;
  logic [mkdlp_pkg::PIN_BITS-1:0]   pin_levels;
  logic [mkdlp_pkg::KEY_IDX_W-1:0]  key_index;
  logic                             out_valid;
  logic                             out_ready;
  logic [1:0]                       key_event;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [mkdlp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mkdlp_pkg::CFG_DATA_W-1:0] cfg_data;

  // per-key debounce machines and the queue of events that get words must return
  class key_event_board;
    logic [mkdlp_pkg::MS_W-1:0]   debounce_ms;
    logic [mkdlp_pkg::MS_W-1:0]   long_press_ms;
    logic                         active_level;
    mkdlp_pkg::phase_t            phase    [NKEYS];
    logic [mkdlp_pkg::TIME_W-1:0] start_ms [NKEYS];
    mkdlp_pkg::event_t            latched  [NKEYS];
    mkdlp_pkg::event_t            expected_events [$];
    int unsigned                  fail_count;
    int unsigned                  read_count;
    int unsigned                  scan_count;
    int unsigned                  click_count;
    int unsigned                  long_count;

    function new();
      debounce_ms   = mkdlp_pkg::DEBOUNCE_RST;
      long_press_ms = mkdlp_pkg::LONG_RST;
      active_level  = 1'b0;
      foreach (phase[i]) begin
        phase[i]    = mkdlp_pkg::PH_IDLE;
        start_ms[i] = '0;
        latched[i]  = mkdlp_pkg::EV_NONE;
      end
      fail_count  = 0;
      read_count  = 0;
      scan_count  = 0;
      click_count = 0;
      long_count  = 0;
    endfunction

    // register write; unknown indexes are dropped
    function void write_reg(logic [mkdlp_pkg::CFG_IDX_W-1:0] idx,
                            logic [mkdlp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mkdlp_pkg::CFG_DEBOUNCE: debounce_ms = data;
        mkdlp_pkg::CFG_LONG:     long_press_ms = data;
        mkdlp_pkg::CFG_ACTIVE:   active_level = data[0];
        default: ;
      endcase
    endfunction

    // accepted input word: scan updates all keys, get queues one event
    function void note_word(mkdlp_pkg::op_t op, logic [mkdlp_pkg::TIME_W-1:0] now,
                            logic [mkdlp_pkg::PIN_BITS-1:0] pins,
                            logic [mkdlp_pkg::KEY_IDX_W-1:0] idx);
      logic [mkdlp_pkg::TIME_W-1:0] elapsed;
      logic                         down;
      logic                         level;
      if (op == mkdlp_pkg::OP_GET) begin
        if (idx < NKEYS) begin
          if (latched[idx] == mkdlp_pkg::EV_CLICK) click_count++;
          if (latched[idx] == mkdlp_pkg::EV_LONG) long_count++;
          expected_events.push_back(latched[idx]);
          latched[idx] = mkdlp_pkg::EV_NONE;
        end else begin
          expected_events.push_back(mkdlp_pkg::EV_NONE);
        end
        return;
      end
      scan_count++;
      // keys past the pin word read level 0
      for (int i = 0; i < NKEYS; i++) begin
        level   = (i < mkdlp_pkg::PIN_BITS) ? pins[i] : 1'b0;
        down    = (level == active_level);
        elapsed = now - start_ms[i];
        case (phase[i])
          mkdlp_pkg::PH_IDLE: begin
            if (down) begin
              phase[i]    = mkdlp_pkg::PH_DEBOUNCE;
              start_ms[i] = now;
            end
          end
          mkdlp_pkg::PH_DEBOUNCE: begin
            if (elapsed > debounce_ms) begin
              if (down) begin
                phase[i]    = mkdlp_pkg::PH_PRESSED;
                start_ms[i] = now;
              end else begin
                phase[i] = mkdlp_pkg::PH_IDLE;
              end
            end
          end
          mkdlp_pkg::PH_PRESSED: begin
            if (!down) begin
              phase[i]   = mkdlp_pkg::PH_IDLE;
              latched[i] = mkdlp_pkg::EV_CLICK;
            end else if (elapsed > long_press_ms) begin
              phase[i]   = mkdlp_pkg::PH_LONG;
              latched[i] = mkdlp_pkg::EV_LONG;
            end
          end
          default: begin
            if (!down) phase[i] = mkdlp_pkg::PH_IDLE;
          end
        endcase
      end
    endfunction

    // accepted result word against the oldest queued event
    function void check_result(logic [1:0] got);
      mkdlp_pkg::event_t want;
      if (expected_events.size() == 0) begin
        $error("key_event: got %0d with no get word outstanding", got);
        fail_count++;
        return;
      end
      want = expected_events.pop_front();
      read_count++;
      if (got !== want) begin
        $error("key_event: expected %0d, actual %0d", want, got);
        fail_count++;
      end
    endfunction
  endclass

  key_event_board               board;
  int unsigned                  burst_left;
  int unsigned                  settings_count;
  bit                           hold_req;
  int unsigned                  hold_len;
  logic [mkdlp_pkg::TIME_W-1:0] clock_ms;
  logic [NKEYS-1:0]             held;

  multi_key_debounce_long_press_core #(.KEY_COUNT(NKEYS)) i_dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watch all three channels at each edge; results first, then new words
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_result(key_event);
      if (in_valid && in_ready) begin
        board.note_word(mkdlp_pkg::op_t'(operation), now_ms, pin_levels, key_index);
      end
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : rx_side
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= cyc[2];
        endcase
      end
    end
  end

  // offer one word and hold it until taken; bursts end in a random gap
  task automatic offer(input mkdlp_pkg::op_t op, input logic [mkdlp_pkg::TIME_W-1:0] now,
                       input logic [mkdlp_pkg::PIN_BITS-1:0] pins,
                       input logic [mkdlp_pkg::KEY_IDX_W-1:0] idx);
    int unsigned gap;
    in_valid   <= 1'b1;
    operation  <= op;
    now_ms     <= now;
    pin_levels <= pins;
    key_index  <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and wait out every outstanding get
  task automatic drain();
    in_valid <= 1'b0;
    // let the monitor record the last accepted word first
    @(posedge clk);
    while (board.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, valid left high for a following write
  task automatic cfg_write(input logic [mkdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mkdlp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_timing(input logic [mkdlp_pkg::CFG_DATA_W-1:0] db,
                            input logic [mkdlp_pkg::CFG_DATA_W-1:0] lp,
                            input logic [mkdlp_pkg::CFG_DATA_W-1:0] lvl);
    cfg_write(mkdlp_pkg::CFG_DEBOUNCE, db);
    cfg_write(mkdlp_pkg::CFG_LONG, lp);
    cfg_write(mkdlp_pkg::CFG_ACTIVE, lvl);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // hand-picked words at reset timing: 20 ms debounce, 1000 ms long press, pressed = 0
  task automatic directed_words();
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'd0);                // nothing latched after reset
    offer(mkdlp_pkg::OP_GET, '1, '1, 8'(NKEYS));           // first id past the last key
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'hFF);
    offer(mkdlp_pkg::OP_SCAN, 32'd100, 4'hF, 8'd0);        // all released
    offer(mkdlp_pkg::OP_SCAN, 32'd100, 4'hC, 8'd0);        // keys 0 and 1 start debounce
    offer(mkdlp_pkg::OP_SCAN, 32'd120, 4'hC, 8'd0);        // exactly the debounce time: no change
    offer(mkdlp_pkg::OP_SCAN, 32'd121, 4'hE, 8'd0);        // key 0 confirmed, key 1 bounced back
    offer(mkdlp_pkg::OP_SCAN, 32'd500, 4'hF, 8'd0);        // key 0 release gives a click
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'd0);
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'd0);                // read clears the event
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'd1);
    offer(mkdlp_pkg::OP_SCAN, 32'd1000, 4'hB, 8'd0);       // key 2 down
    offer(mkdlp_pkg::OP_SCAN, 32'd1021, 4'hB, 8'd0);       // confirmed at 1021
    offer(mkdlp_pkg::OP_SCAN, 32'd2021, 4'hB, 8'd0);       // exactly the long-press time
    offer(mkdlp_pkg::OP_SCAN, 32'd2022, 4'hB, 8'd0);       // long press latched
    offer(mkdlp_pkg::OP_SCAN, 32'd2030, 4'hF, 8'd0);       // release after long press: no click
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'd2);
    offer(mkdlp_pkg::OP_SCAN, 32'hFFFF_FFF0, 4'h7, 8'd0);  // key 3 down just before the wrap
    offer(mkdlp_pkg::OP_SCAN, 32'h0000_0005, 4'h7, 8'd0);  // elapsed 21 across the wrap
    offer(mkdlp_pkg::OP_SCAN, 32'hFFFF_FFFF, 4'h7, 8'd0);  // time runs backward: huge elapsed
    offer(mkdlp_pkg::OP_SCAN, 32'h0000_0010, 4'hF, 8'd0);
    offer(mkdlp_pkg::OP_GET, '1, '1, 8'd3);
    offer(mkdlp_pkg::OP_GET, '0, '0, 8'd3);
    clock_ms = 32'h0000_0010;
    held     = '0;
  endtask

  // press and release sequences with time steps scaled to the current limits
  task automatic run_random(input int unsigned n_items);
    int unsigned                     k;
    int unsigned                     r;
    int unsigned                     stepv;
    int unsigned                     db;
    int unsigned                     lp;
    logic [mkdlp_pkg::PIN_BITS-1:0]  pins;
    logic [mkdlp_pkg::KEY_IDX_W-1:0] idx;
    for (k = 0; k < n_items; k++) begin
      db = board.debounce_ms;
      lp = board.long_press_ms;
      r  = $urandom_range(0, 99);
      if (r < 22) begin
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, NKEYS - 1));
        offer(mkdlp_pkg::OP_GET, $urandom, 4'($urandom), idx);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) stepv = 0;
        else if (r < 50) stepv = $urandom_range(0, db + 2);
        else if (r < 85) stepv = $urandom_range(0, lp / 3 + 2);
        else if (r < 97) stepv = $urandom_range(db, lp + db + 2);
        else stepv = $urandom;
        clock_ms += stepv;
        for (int i = 0; i < NKEYS; i++) begin
          if ($urandom_range(0, 7) == 0) held[i] = ~held[i];
        end
        pins = board.active_level ? held : ~held;
        // contact bounce on a few scans
        if ($urandom_range(0, 9) == 0) pins ^= 4'($urandom);
        offer(mkdlp_pkg::OP_SCAN, clock_ms, pins, 8'($urandom));
      end
    end
  endtask

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("multi_key_debounce_long_press_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= mkdlp_pkg::OP_SCAN;
    now_ms     <= '0;
    pin_levels <= '0;
    key_index  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= mkdlp_pkg::CFG_DEBOUNCE;
    cfg_data   <= '0;
    board          = new();
    burst_left     = 0;
    settings_count = 1;
    hold_req       = 1'b0;
    hold_len       = 0;
    clock_ms       = '0;
    held           = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timing
    directed_words();
    run_random(150);

    // zero limits, pressed = 1, and a long receiver hold-off
    drain();
    cfg_write(CFG_UNUSED, 16'hFFFF);
    set_timing(16'd0, 16'd0, 16'd1);
    hold_len = 300;
    hold_req = 1'b1;
    run_random(150);

    // widest limits, time close to the wrap
    drain();
    clock_ms = 32'hFFFF_0000;
    set_timing(16'hFFFF, 16'hFFFF, 16'h0000);
    run_random(150);

    // short limits
    drain();
    set_timing(16'd3, 16'd12, 16'd1);
    run_random(200);

    // moderate random limits; active level data carries junk upper bits
    drain();
    set_timing(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)), 16'($urandom));
    run_random(200);

    // fully random limits
    drain();
    set_timing(16'($urandom), 16'($urandom), 16'($urandom));
    run_random(150);

    drain();
    repeat (8) @(posedge clk);
    if (board.expected_events.size() != 0) begin
      $error("key_event: %0d expected results never arrived", board.expected_events.size());
      board.fail_count++;
    end
    $display("run covered %0d scans and %0d event reads (%0d clicks, %0d long presses)",
             board.scan_count, board.read_count, board.click_count, board.long_count);
    $display("over %0d timing settings, with bursty input and a long output hold-off",
             settings_count);
    if (board.fail_count == 0) begin
      $display("multi_key_debounce_long_press_core: match");
    end else begin
      $display("multi_key_debounce_long_press_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mkdlp_pkg.sv
rtl/mkdlp_lane.sv
rtl/mkdlp_merge.sv
rtl/multi_key_debounce_long_press_core.sv
rtl/mkdlp_checker.sv
tb/sv/tb_multi_key_debounce_long_press_core.sv
